/* src/sta_pkg.sv */
// Shared types and constants for the similarity transform accumulator.
// Holds the queue entry layout, back-end sequencer codes and the CORDIC arctangent table.
// No dependencies.
package sta_pkg;

	localparam logic [15:0]        MAX_GAP_RESET = 16'd5;
	localparam logic signed [31:0] ONE_Q16       = 32'sd65536;
	localparam logic signed [31:0] GAIN_Q30      = 32'sd652032874;
	localparam logic signed [33:0] HALF_PI_Q30   = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30        = 34'sd3373259426;

	// classified request, passed from front to back
	typedef struct packed {
		logic [15:0]        stored_index;
		logic [15:0]        fill_count;
		logic               was_reset;
		logic               store_full;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [18:0] angle;
		logic signed [23:0] scale;
	} sta_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CORDIC,
		BK_MUL,
		BK_FIN
	} back_state_t;

	// order of the shared multiplier's operations
	typedef enum logic [3:0] {
		MS_A,
		MS_B,
		MS_PP,
		MS_PQ,
		MS_QQ,
		MS_QP,
		MS_XX,
		MS_XY,
		MS_YY,
		MS_YX
	} mul_step_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
		logic signed [31:0] r;
		case (idx)
			5'd0:  r = 32'sd843314857;
			5'd1:  r = 32'sd497837829;
			5'd2:  r = 32'sd263043837;
			5'd3:  r = 32'sd133525159;
			5'd4:  r = 32'sd67021687;
			5'd5:  r = 32'sd33543516;
			5'd6:  r = 32'sd16775851;
			5'd7:  r = 32'sd8388437;
			5'd8:  r = 32'sd4194283;
			5'd9:  r = 32'sd2097149;
			5'd10: r = 32'sd1048576;
			5'd11: r = 32'sd524288;
			5'd12: r = 32'sd262144;
			5'd13: r = 32'sd131072;
			5'd14: r = 32'sd65536;
			5'd15: r = 32'sd32768;
			5'd16: r = 32'sd16384;
			5'd17: r = 32'sd8192;
			5'd18: r = 32'sd4096;
			5'd19: r = 32'sd2048;
			5'd20: r = 32'sd1024;
			5'd21: r = 32'sd512;
			5'd22: r = 32'sd256;
			5'd23: r = 32'sd128;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

/* src/similarity_transform_accumulator.sv */
// Similarity transform accumulator: front end classifies records, back end composes them.
// The back end finishes one record before it takes the next, as set by the iterative CORDIC and the
// single shared multiplier (ten products per record); the front takes up to two records ahead.
// Reset (arst_n low): running transform to identity, slot count to zero, max_gap to 5.
// Depends on sta_pkg, sta_front, sta_queue and sta_back.
module similarity_transform_accumulator import sta_pkg::*; #(
	parameter int INDEX_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        frame_number,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [18:0] angle,
	input  logic signed [23:0] scale,
	input  logic               pop,
	output logic               empty,
	output logic [15:0]        stored_index,
	output logic [15:0]        fill_count,
	output logic signed [31:0] coef_p,
	output logic signed [31:0] coef_q,
	output logic signed [31:0] offset_x,
	output logic signed [31:0] offset_y,
	output logic               was_reset,
	output logic               saturated
);

	localparam logic REG_MAX_GAP = 1'b0;

	logic [15:0] max_gap_q;
	logic        cfg_wr;
	logic        q_wr, q_rd, q_empty;
	sta_item_t   q_wdata, q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MAX_GAP) ? {16'd0, max_gap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= MAX_GAP_RESET;
		end else if (cfg_wr && paddr[2] == REG_MAX_GAP) begin
			max_gap_q <= pwdata[15:0];
		end
	end

	sta_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (full),
		.frame_number(frame_number),
		.shift_x     (shift_x),
		.shift_y     (shift_y),
		.angle       (angle),
		.scale       (scale),
		.max_gap     (max_gap_q),
		.q_wr        (q_wr),
		.q_data      (q_wdata)
	);

	sta_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(q_wdata),
		.full   (full),
		.rd     (q_rd),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	sta_back #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.stored_index(stored_index),
		.fill_count  (fill_count),
		.coef_p      (coef_p),
		.coef_q      (coef_q),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.was_reset   (was_reset),
		.saturated   (saturated)
	);

endmodule

/* src/sta_front.sv */
// Front end: accepts motion records, works out gap, reset, target slot and fill count.
// Keeps the stored slot count. Depends on sta_pkg.
module sta_front import sta_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               q_full,
	input  logic [15:0]        frame_number,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [18:0] angle,
	input  logic signed [23:0] scale,
	input  logic [15:0]        max_gap,
	output logic               q_wr,
	output sta_item_t          q_data
);

	localparam int CW = INDEX_BITS + 1;
	localparam int TW = (CW > 17) ? CW : 17;

	logic [CW-1:0] count_q;
	logic [TW-1:0] frame_w, count_w, gap_w, target_w, fill_w;
	logic          behind, restart, store_full;

	always_comb begin
		frame_w    = TW'(frame_number);
		count_w    = TW'(count_q);
		behind     = frame_w < count_w;
		gap_w      = frame_w - count_w;
		restart    = behind || (gap_w > TW'(max_gap));
		target_w   = behind ? count_w : frame_w;
		store_full = |target_w[TW-1:INDEX_BITS];
		fill_w     = store_full ? '0 : (target_w - count_w);
	end

	assign q_wr = push && !q_full;

	always_comb begin
		q_data.stored_index = target_w[15:0];
		q_data.fill_count   = fill_w[15:0];
		q_data.was_reset    = restart;
		q_data.store_full   = store_full;
		q_data.shift_x      = shift_x;
		q_data.shift_y      = shift_y;
		q_data.angle        = angle;
		q_data.scale        = scale;
	end

	// hold the count when the store is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_wr && !store_full) begin
			count_q <= CW'(target_w + TW'(1));
		end
	end

endmodule

/* src/sta_queue.sv */
// Two-entry queue of classified requests between front and back end.
// Depends on sta_pkg for the entry type.
module sta_queue import sta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  sta_item_t wr_data,
	output logic      full,
	input  logic      rd,
	output sta_item_t rd_data,
	output logic      empty
);

	sta_item_t  entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* src/sta_back.sv */
// Back end: iterative CORDIC, shared-multiplier composition onto the running transform,
// rounding and saturation, and the result register. Depends on sta_pkg.
module sta_back import sta_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sta_item_t          q_data,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [15:0]        stored_index,
	output logic [15:0]        fill_count,
	output logic signed [31:0] coef_p,
	output logic signed [31:0] coef_q,
	output logic signed [31:0] offset_x,
	output logic signed [31:0] offset_y,
	output logic               was_reset,
	output logic               saturated
);

	localparam int SW   = $clog2(CORDIC_STEPS);
	localparam int ACCW = 60;
	localparam int RW   = ACCW - 15;
	localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

	back_state_t state_q, state_d;
	logic        load_out;

	sta_item_t          item_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic               neg_q;
	logic [SW-1:0]      step_q;
	mul_step_t          mstep_q;
	logic signed [25:0] a_q, b_q;
	logic signed [ACCW-1:0] acc_p_q, acc_q_q, acc_x_q, acc_y_q;
	logic signed [31:0] run_p_q, run_q_q, run_x_q, run_y_q;
	logic               out_valid_q;

	logic signed [33:0] z_full, z_red;
	logic               z_neg;
	logic signed [31:0] dx, dy, atan_w, cos_w, sin_w;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod, rnd30;
	logic [32:0]        res_p, res_q, res_x, res_y;

	// round Q32 sum to Q16.16, add the shift, clip to 32 bits; flag in the top bit
	function automatic logic [32:0] round_sat(input logic signed [ACCW-1:0] acc,
		input logic signed [31:0] shift);
		logic signed [ACCW-1:0] t;
		logic signed [RW-1:0]   wide;
		logic                   ovf;
		logic [31:0]            v;
		t    = acc + ACCW'(32768);
		wide = $signed(t[ACCW-1:16]) + shift;
		ovf  = !((&wide[RW-1:31]) || !(|wide[RW-1:31]));
		if (ovf) begin
			v = wide[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			v = wide[31:0];
		end
		return {ovf, v};
	endfunction

	// angle reduction into plus or minus half pi
	always_comb begin
		z_full = 34'(q_data.angle) <<< 14;
		z_neg  = 1'b0;
		z_red  = z_full;
		if (z_full > HALF_PI_Q30) begin
			z_red = z_full - PI_Q30;
			z_neg = 1'b1;
		end else if (z_full < -HALF_PI_Q30) begin
			z_red = z_full + PI_Q30;
			z_neg = 1'b1;
		end
	end

	always_comb begin
		dx     = y_q >>> step_q;
		dy     = x_q >>> step_q;
		atan_w = atan_q30(5'(step_q));
		cos_w  = neg_q ? -x_q : x_q;
		sin_w  = neg_q ? -y_q : y_q;
	end

	always_comb begin
		unique case (mstep_q)
			MS_A:  begin mul_a = 32'(item_q.scale); mul_b = cos_w;   end
			MS_B:  begin mul_a = 32'(item_q.scale); mul_b = sin_w;   end
			MS_PP: begin mul_a = 32'(a_q);          mul_b = run_p_q; end
			MS_PQ: begin mul_a = 32'(b_q);          mul_b = run_q_q; end
			MS_QQ: begin mul_a = 32'(a_q);          mul_b = run_q_q; end
			MS_QP: begin mul_a = 32'(b_q);          mul_b = run_p_q; end
			MS_XX: begin mul_a = 32'(a_q);          mul_b = run_x_q; end
			MS_XY: begin mul_a = 32'(b_q);          mul_b = run_y_q; end
			MS_YY: begin mul_a = 32'(a_q);          mul_b = run_y_q; end
			MS_YX: begin mul_a = 32'(b_q);          mul_b = run_x_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod  = mul_a * mul_b;
		rnd30 = prod + 64'sd536870912;
	end

	always_comb begin
		res_p = round_sat(acc_p_q, 32'sd0);
		res_q = round_sat(acc_q_q, 32'sd0);
		res_x = round_sat(acc_x_q, item_q.shift_x);
		res_y = round_sat(acc_y_q, item_q.shift_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_rd     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_d = BK_CORDIC;
				end
			end
			BK_CORDIC: begin
				if (step_q == LAST_STEP) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				if (mstep_q == MS_YX) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				// wait for the result register to drain
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q  <= q_data;
			z_q     <= z_red[31:0];
			neg_q   <= z_neg;
			x_q     <= GAIN_Q30;
			y_q     <= '0;
			step_q  <= '0;
			mstep_q <= MS_A;
		end else if (state_q == BK_CORDIC) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_w;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_w;
			end
			step_q <= step_q + SW'(1);
		end else if (state_q == BK_MUL) begin
			unique case (mstep_q)
				MS_A:  a_q     <= rnd30[55:30];
				MS_B:  b_q     <= rnd30[55:30];
				MS_PP: acc_p_q <= prod[ACCW-1:0];
				MS_PQ: acc_p_q <= acc_p_q - prod[ACCW-1:0];
				MS_QQ: acc_q_q <= prod[ACCW-1:0];
				MS_QP: acc_q_q <= acc_q_q + prod[ACCW-1:0];
				MS_XX: acc_x_q <= prod[ACCW-1:0];
				MS_XY: acc_x_q <= acc_x_q + prod[ACCW-1:0];
				MS_YY: acc_y_q <= prod[ACCW-1:0];
				MS_YX: acc_y_q <= acc_y_q - prod[ACCW-1:0];
				default: a_q   <= a_q;
			endcase
			if (mstep_q != MS_YX) begin
				mstep_q <= mul_step_t'(mstep_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_p_q <= ONE_Q16;
			run_q_q <= '0;
			run_x_q <= '0;
			run_y_q <= '0;
		end else if (q_rd && q_data.was_reset) begin
			run_p_q <= ONE_Q16;
			run_q_q <= '0;
			run_x_q <= '0;
			run_y_q <= '0;
		end else if (load_out) begin
			run_p_q <= res_p[31:0];
			run_q_q <= res_q[31:0];
			run_x_q <= res_x[31:0];
			run_y_q <= res_y[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			stored_index <= item_q.stored_index;
			fill_count   <= item_q.fill_count;
			coef_p       <= res_p[31:0];
			coef_q       <= res_q[31:0];
			offset_x     <= res_x[31:0];
			offset_y     <= res_y[31:0];
			was_reset    <= item_q.was_reset;
			saturated    <= item_q.store_full || res_p[32] || res_q[32] ||
				res_x[32] || res_y[32];
		end
	end

	assign empty = !out_valid_q;

endmodule

/* bench/similarity_transform_accumulator_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for similarity_transform_accumulator: drives motion records and max_gap
// writes, predicts every stored transform in a scoreboard class. Needs only the RTL under src/.
module similarity_transform_accumulator_tb;

	localparam int     MAX_GAP_INDEX = 0;
	localparam int     SPARE_INDEX   = 1;
	localparam int     IDLE_LIMIT    = 4000;
	localparam int     PHASE_ITEMS   = 220;
	localparam int     TRIG_STEPS    = 16;
	localparam longint UNITY_Q16     = 65536;
	localparam longint CORDIC_START  = 64'sd652032874;
	localparam longint QUARTER_TURN  = 64'sd1686629713;
	localparam longint HALF_TURN     = 64'sd3373259426;
	localparam longint SLOT_CAPACITY = 65536;
	localparam longint ARCTAN_Q30 [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
		524288, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	typedef struct {
		logic [15:0]        frame_number;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [18:0] angle;
		logic signed [23:0] scale;
	} motion_rec_t;

	typedef struct {
		logic [15:0]        stored_index;
		logic [15:0]        fill_count;
		logic signed [31:0] coef_p;
		logic signed [31:0] coef_q;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic               was_reset;
		logic               saturated;
	} transform_t;

	class transform_tracker;
		longint unsigned max_gap;
		longint unsigned slots;
		longint          run_p, run_q, run_x, run_y;
		int              mismatches;
		transform_t      pending_transforms[$];

		function new();
			max_gap = 5;
			slots = 0;
			run_p = UNITY_Q16;
			run_q = 0;
			run_x = 0;
			run_y = 0;
			mismatches = 0;
		endfunction

		function void set_register(int index, logic [31:0] value);
			if (index == MAX_GAP_INDEX)
				max_gap = value[15:0];
		endfunction

		function void check_readback(logic [31:0] value);
			if (value !== 32'(max_gap)) begin
				$error("max_gap readback: expected %0d, got %0d", max_gap, value);
				mismatches++;
			end
		endfunction

		function longint clip32(longint v, inout bit flag);
			if (v > 64'sd2147483647) begin
				flag = 1'b1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				flag = 1'b1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// cos and sin in Q30, gain folded into the start vector
		function void rotate(longint ang, output longint c, output longint s);
			longint z, x, y, dx, dy;
			bit     flip;
			int     i;
			z = ang * 16384;
			x = CORDIC_START;
			y = 0;
			flip = 1'b0;
			if (z > QUARTER_TURN) begin
				z -= HALF_TURN;
				flip = 1'b1;
			end else if (z < -QUARTER_TURN) begin
				z += HALF_TURN;
				flip = 1'b1;
			end
			for (i = 0; i < TRIG_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= ARCTAN_Q30[i];
				end else begin
					x += dx;
					y -= dy;
					z += ARCTAN_Q30[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_record(motion_rec_t r);
			longint unsigned frame, target, fill;
			longint          sx, sy, ang, scl, c, s, a, b, np, nq, nx, ny;
			bit              restart, clip;
			transform_t      e;
			frame = r.frame_number;
			sx = r.shift_x;
			sy = r.shift_y;
			ang = r.angle;
			scl = r.scale;
			clip = 1'b0;
			fill = 0;
			// a frame behind the count wraps the gap, so it restarts too
			restart = (frame < slots) || (frame - slots > max_gap);
			target = (frame > slots) ? frame : slots;
			if (target >= SLOT_CAPACITY)
				clip = 1'b1;
			else begin
				fill = target - slots;
				slots = target + 1;
			end
			if (restart) begin
				run_p = UNITY_Q16;
				run_q = 0;
				run_x = 0;
				run_y = 0;
			end
			rotate(ang, c, s);
			a = (scl * c + 64'sd536870912) >>> 30;
			b = (scl * s + 64'sd536870912) >>> 30;
			np = clip32((a * run_p - b * run_q + 32768) >>> 16, clip);
			nq = clip32((a * run_q + b * run_p + 32768) >>> 16, clip);
			nx = clip32(((a * run_x + b * run_y + 32768) >>> 16) + sx, clip);
			ny = clip32(((a * run_y - b * run_x + 32768) >>> 16) + sy, clip);
			run_p = np;
			run_q = nq;
			run_x = nx;
			run_y = ny;
			e.stored_index = target[15:0];
			e.fill_count = fill[15:0];
			e.coef_p = np[31:0];
			e.coef_q = nq[31:0];
			e.offset_x = nx[31:0];
			e.offset_y = ny[31:0];
			e.was_reset = restart;
			e.saturated = clip;
			pending_transforms.insert(pending_transforms.size(), e);
		endfunction

		function void compare_field(string name, longint expd, longint act);
			if (expd != act) begin
				$error("%s: expected %0d, got %0d", name, expd, act);
				mismatches++;
			end
		endfunction

		function void check_transform(transform_t got);
			transform_t e;
			if (pending_transforms.size() == 0) begin
				$error("unrequested result at stored_index %0d", got.stored_index);
				mismatches++;
				return;
			end
			e = pending_transforms.pop_front();
			compare_field("stored_index", e.stored_index, got.stored_index);
			compare_field("fill_count", e.fill_count, got.fill_count);
			compare_field("coef_p", e.coef_p, got.coef_p);
			compare_field("coef_q", e.coef_q, got.coef_q);
			compare_field("offset_x", e.offset_x, got.offset_x);
			compare_field("offset_y", e.offset_y, got.offset_y);
			compare_field("was_reset", e.was_reset, got.was_reset);
			compare_field("saturated", e.saturated, got.saturated);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               push;
	logic               full;
	logic [15:0]        frame_number;
	logic signed [31:0] shift_x;
	logic signed [31:0] shift_y;
	logic signed [18:0] angle;
	logic signed [23:0] scale;
	logic               pop;
	logic               empty;
	logic [15:0]        stored_index;
	logic [15:0]        fill_count;
	logic signed [31:0] coef_p;
	logic signed [31:0] coef_q;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic               was_reset;
	logic               saturated;

	transform_tracker tracker = new();

	similarity_transform_accumulator uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly back to back or short, now and then a long pause
	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic motion_rec_t make_record(int frame, int sx, int sy, int ang, int scl);
		motion_rec_t r;
		r.frame_number = frame[15:0];
		r.shift_x = sx;
		r.shift_y = sy;
		r.angle = ang[18:0];
		r.scale = scl[23:0];
		return r;
	endfunction

	function automatic motion_rec_t random_record();
		motion_rec_t     r;
		int unsigned     roll, gap;
		longint unsigned next_slot, frame;
		int              scl;
		next_slot = tracker.slots;
		roll = $urandom_range(0, 99);
		if (roll < 6 && next_slot > 0)
			frame = $urandom_range(0, int'(next_slot - 1));
		else if (roll < 8 && next_slot < 40000)
			frame = $urandom_range(int'(next_slot), 50000);
		else begin
			if (roll < 20)
				gap = (tracker.max_gap < 300) ? int'(tracker.max_gap) + 1 + $urandom_range(0, 20)
					: $urandom_range(0, 300);
			else
				gap = $urandom_range(0, (tracker.max_gap < 6) ? int'(tracker.max_gap) : 6);
			frame = next_slot + gap;
		end
		// hold the last slot back for the store-full finish
		if (frame > 65534)
			frame = 65534;
		r.frame_number = frame[15:0];
		r.shift_x = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2097152) - 1048576;
		r.shift_y = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2097152) - 1048576;
		if ($urandom_range(0, 99) < 85)
			r.angle = 19'($urandom_range(0, 411774) - 205887);
		else
			r.angle = 19'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			scl = $urandom_range(49152, 81920);
			r.scale = $urandom_range(0, 1) ? 24'(-scl) : 24'(scl);
		end else if (roll < 90)
			r.scale = 24'($urandom_range(0, 262144) - 131072);
		else
			r.scale = 24'($urandom);
		return r;
	endfunction

	task automatic send_record(input motion_rec_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		frame_number <= r.frame_number;
		shift_x <= r.shift_x;
		shift_y <= r.shift_y;
		angle <= r.angle;
		scale <= r.scale;
		do @(posedge clk); while (full);
		tracker.note_record(r);
	endtask

	task automatic write_register(input int index, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(index * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(index, data);
		if (index == MAX_GAP_INDEX) begin
			pwrite <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			tracker.check_readback(prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (tracker.pending_transforms.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: random pops, one long hold-off so the block backs up
	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (taken == 150) ? 600 : pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken++;
		end
	end

	always @(posedge clk) begin
		transform_t got;
		if (arst_n && pop && !empty) begin
			got.stored_index = stored_index;
			got.fill_count = fill_count;
			got.coef_p = coef_p;
			got.coef_q = coef_q;
			got.offset_x = offset_x;
			got.offset_y = offset_y;
			got.was_reset = was_reset;
			got.saturated = saturated;
			tracker.check_transform(got);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[similarity_transform_accumulator] ERROR");
		$finish;
	end

	initial begin : stimulus
		int          phase;
		int          n;
		int unsigned setting;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		push <= 1'b0;
		frame_number <= '0;
		shift_x <= '0;
		shift_y <= '0;
		angle <= '0;
		scale <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset max_gap of 5 still in force
		send_record(make_record(0, 0, 0, 0, 65536));
		send_record(make_record(3, 32'h7fffffff, 32'h80000000, 205887, 65536));
		send_record(make_record(4, 32'h80000000, 32'h7fffffff, -205887, -65536));
		send_record(make_record(10, 65536, -65536, 262143, 98304));
		send_record(make_record(17, 12345, -54321, -262144, 32768));
		send_record(make_record(2, 0, 0, 102944, 65536));
		send_record(make_record(19, 100, 200, 102943, 65536));
		send_record(make_record(20, -100, -200, -102944, 65536));
		send_record(make_record(21, 0, 0, -102943, 70000));
		send_record(make_record(22, 0, 0, 0, 8388607));
		send_record(make_record(23, 0, 0, 0, 8388607));
		send_record(make_record(24, 0, 0, 0, 8388607));
		send_record(make_record(25, 0, 0, 0, -8388608));
		send_record(make_record(26, 777, -777, 50000, 0));
		send_record(make_record(27, 32'h55555555, 32'haaaaaaaa, 87381, 65536));
		send_record(make_record(27, 1, 1, -87382, 65536));
		push <= 1'b0;

		for (phase = 0; phase < 5; phase++) begin
			wait_for_results();
			case (phase)
				0: setting = 0;
				1: setting = 65535;
				2: setting = $urandom_range(1, 20);
				3: setting = $urandom_range(0, 65535);
				default: setting = 2;
			endcase
			if (phase == 0)
				write_register(SPARE_INDEX, $urandom);
			write_register(MAX_GAP_INDEX, {16'($urandom), 16'(setting)});
			for (n = 0; n < PHASE_ITEMS; n++)
				send_record(random_record());
			push <= 1'b0;
		end

		// fill the last slot, then the store is full for good
		wait_for_results();
		write_register(MAX_GAP_INDEX, 32'd5);
		send_record(make_record(65535, 4096, -4096, 1000, 65536));
		send_record(make_record(0, 0, 0, -1000, 65536));
		send_record(make_record(65535, 10, 20, 205887, -65536));
		send_record(make_record(1234, -10, -20, 0, 131072));
		push <= 1'b0;

		wait_for_results();
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[similarity_transform_accumulator] OK");
		else
			$display("[similarity_transform_accumulator] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
src/sta_pkg.sv
src/sta_front.sv
src/sta_queue.sv
src/sta_back.sv
src/similarity_transform_accumulator.sv
bench/similarity_transform_accumulator_tb.sv
